/* sv/dnsq_pkg.sv */
// Package for the DNS question section parser.
// Holds the transaction structs, phase enum, result kind codes and parser constants.
// No dependencies; used by every module of the block.
package dnsq_pkg;

  // Parser constants
  localparam logic [7:0] DotCode  = 8'd46;
  localparam logic [7:0] MaxLabel = 8'd63;

  // Result kind codes
  localparam logic [1:0] KIND_CHAR  = 2'd0;
  localparam logic [1:0] KIND_TYPE  = 2'd1;
  localparam logic [1:0] KIND_CLASS = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  // Parser phase
  typedef enum logic [2:0] {
    PH_DONE      = 3'd0,
    PH_LEN_FIRST = 3'd1,
    PH_LEN_NEXT  = 3'd2,
    PH_LABEL     = 3'd3,
    PH_TYPE_HI   = 3'd4,
    PH_TYPE_LO   = 3'd5,
    PH_CLASS_HI  = 3'd6,
    PH_CLASS_LO  = 3'd7
  } phase_t;

  // Input transaction
  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] value;
    logic        last;
  } out_item_t;

  // Parser state carried from byte to byte
  typedef struct packed {
    phase_t     phase;
    logic [5:0] label_left;
    logic [7:0] held_high;
  } parse_state_t;

endpackage

/* sv/dnsq_step.sv */
// Next-state and result logic for one byte of the question section.
// Depends on dnsq_pkg for the state, transaction and kind types.
module dnsq_step (
  input  dnsq_pkg::parse_state_t cur_state,
  input  dnsq_pkg::in_item_t     in_item,
  output dnsq_pkg::parse_state_t nxt_state,
  output logic                   res_emit,
  output dnsq_pkg::out_item_t    res_item
);

  dnsq_pkg::parse_state_t eff;

  // Restart on a first byte: clear counters, treat byte as first length byte
  always_comb begin
    eff = cur_state;
    if (in_item.first) begin
      eff.phase      = dnsq_pkg::PH_LEN_FIRST;
      eff.label_left = '0;
      eff.held_high  = '0;
    end
  end

  // Advance the phase and form the result
  always_comb begin
    nxt_state      = eff;
    res_emit       = 1'b0;
    res_item.kind  = dnsq_pkg::KIND_CHAR;
    res_item.value = {8'd0, in_item.data_byte};
    res_item.last  = 1'b0;
    case (eff.phase)
      dnsq_pkg::PH_LEN_FIRST, dnsq_pkg::PH_LEN_NEXT: begin
        if (in_item.data_byte == 8'd0) begin
          nxt_state.phase = dnsq_pkg::PH_TYPE_HI;
        end else if (in_item.data_byte > dnsq_pkg::MaxLabel) begin
          // oversized length or compression pointer: end with an error
          nxt_state.phase      = dnsq_pkg::PH_DONE;
          nxt_state.label_left = '0;
          res_emit             = 1'b1;
          res_item.kind        = dnsq_pkg::KIND_ERROR;
          res_item.value       = '0;
          res_item.last        = 1'b1;
        end else begin
          nxt_state.phase      = dnsq_pkg::PH_LABEL;
          nxt_state.label_left = in_item.data_byte[5:0];
          res_emit             = (eff.phase == dnsq_pkg::PH_LEN_NEXT);
          res_item.value       = {8'd0, dnsq_pkg::DotCode};
        end
      end
      dnsq_pkg::PH_LABEL: begin
        if (eff.label_left <= 6'd1) begin
          nxt_state.label_left = '0;
          nxt_state.phase      = dnsq_pkg::PH_LEN_NEXT;
        end else begin
          nxt_state.label_left = eff.label_left - 6'd1;
        end
        res_emit = 1'b1;
      end
      dnsq_pkg::PH_TYPE_HI: begin
        nxt_state.held_high = in_item.data_byte;
        nxt_state.phase     = dnsq_pkg::PH_TYPE_LO;
      end
      dnsq_pkg::PH_TYPE_LO: begin
        nxt_state.phase = dnsq_pkg::PH_CLASS_HI;
        res_emit        = 1'b1;
        res_item.kind   = dnsq_pkg::KIND_TYPE;
        res_item.value  = {eff.held_high, in_item.data_byte};
      end
      dnsq_pkg::PH_CLASS_HI: begin
        nxt_state.held_high = in_item.data_byte;
        nxt_state.phase     = dnsq_pkg::PH_CLASS_LO;
      end
      dnsq_pkg::PH_CLASS_LO: begin
        nxt_state.phase = dnsq_pkg::PH_DONE;
        res_emit        = 1'b1;
        res_item.kind   = dnsq_pkg::KIND_CLASS;
        res_item.value  = {eff.held_high, in_item.data_byte};
        res_item.last   = 1'b1;
      end
      default: begin
        // done: ignore bytes until the next first byte
        nxt_state = eff;
      end
    endcase
  end

endmodule

/* sv/dns_question_parser.sv */
// Top level of the DNS question section parser: state registers and result buffer.
// Depends on dnsq_pkg and dnsq_step.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall   | dnsq_pkg::in_item_t  (data_byte, first)
//   out_    | output    | out_valid/out_stall | dnsq_pkg::out_item_t (kind, value, last)
//
// One byte per cycle is accepted while in_stall is low; its result, if any, is
// registered in the output register, or in the skid register if that one is held.
// A two-entry output buffer (output register plus skid register) lets a byte enter
// while a result waits; in_stall rises only once the skid register holds a result.
// Reset (rst_n low, synchronous) returns the parser to done and empties the buffer.
module dns_question_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dnsq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output dnsq_pkg::out_item_t out_data
);

  dnsq_pkg::parse_state_t state_r;
  dnsq_pkg::parse_state_t state_nxt;
  logic                   res_emit;
  dnsq_pkg::out_item_t    res_item;

  logic                   out_valid_r;
  dnsq_pkg::out_item_t    out_item_r;
  logic                   skid_valid_r;
  dnsq_pkg::out_item_t    skid_item_r;

  logic                   in_accept;
  logic                   out_free;
  logic                   res_valid;

  dnsq_step u_step (
    .cur_state (state_r),
    .in_item   (in_data),
    .nxt_state (state_nxt),
    .res_emit  (res_emit),
    .res_item  (res_item)
  );

  assign in_stall  = skid_valid_r;
  assign in_accept = in_valid && !in_stall;
  assign res_valid = in_accept && res_emit;
  assign out_free  = !out_valid_r || !out_stall;

  // Advance parser state on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase      <= dnsq_pkg::PH_DONE;
      state_r.label_left <= '0;
      state_r.held_high  <= '0;
    end else if (in_accept) begin
      state_r <= state_nxt;
    end
  end

  // Output and skid valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r  <= skid_valid_r || res_valid;
      skid_valid_r <= skid_valid_r && res_valid;
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Output and skid payloads; hold while stalled
  always_ff @(posedge clk) begin
    if (out_free) begin
      out_item_r <= skid_valid_r ? skid_item_r : res_item;
    end
    if (res_valid && (!out_free || skid_valid_r)) begin
      skid_item_r <= res_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

/* sv/dnsq_checker.sv */
// Port-level checks for dns_question_parser, attached by bind.
// Depends on dnsq_pkg for the result kind codes.
module dnsq_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input dnsq_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input dnsq_pkg::out_item_t out_data
);

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Mark last exactly on class and error results
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last == ((out_data.kind == dnsq_pkg::KIND_CLASS) ||
                                     (out_data.kind == dnsq_pkg::KIND_ERROR))))
    else $error("last flag does not match result kind");

  // Carry a zero value on error results
  a_err_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == dnsq_pkg::KIND_ERROR) |-> (out_data.value == 16'd0))
    else $error("error result with nonzero value");

  // Drop all results after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("buffer not empty after reset");

  // Accept a first byte: next result cannot be a type or class
  a_first_no_type: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.first && !out_valid |=>
      !(out_valid && ((out_data.kind == dnsq_pkg::KIND_TYPE) ||
                      (out_data.kind == dnsq_pkg::KIND_CLASS))))
    else $error("type or class result right after a first byte");

endmodule

bind dns_question_parser dnsq_checker u_dnsq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
